// ===== rtl/pbs_pkg.sv =====
// shared types, codes and constants of the packed b-frame splitter
package pbs_pkg;

    localparam int LENGTH_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH         = 2;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 32;

    localparam logic [23:0] CODE_SHIFT_INIT  = 24'hFF_FFFF;
    localparam logic [23:0] START_PREFIX     = 24'h00_0001;
    localparam logic [7:0]  VOP_CODE         = 8'hB6;
    localparam int          PREFIX_LEN       = 4;
    localparam int          TAIL_BYTES       = 3;
    localparam logic [7:0]  MIN_LENGTH_RESET = 8'd7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_B_FRAME_FLAGS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH    = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        ST_WHOLE  = 2'd0,
        ST_FIRST  = 2'd1,
        ST_SECOND = 2'd2,
        ST_NOVOP  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_WHOLE,
        KIND_NOVOP,
        KIND_SPLIT
    } kind_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        last_byte;
        logic [31:0] frame_offset;
        logic [31:0] frame_flags;
    } byte_beat_t;

    typedef struct packed {
        logic [31:0] entry_offset;
        logic [23:0] entry_size;
        logic [31:0] entry_flags;
        status_t     status;
        logic        last_of_run;
    } entry_beat_t;

    // one classified frame handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [31:0] offset;
        logic [31:0] flags;
        logic [23:0] size1;
        logic [31:0] offset2;
        logic [23:0] size2;
    } frame_desc_t;

endpackage

// ===== rtl/pbs_front.sv =====
// front end: start code scan and frame classification
module pbs_front
    import pbs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        beat_take,
    input  byte_beat_t  beat,
    input  logic [7:0]  min_length,
    output logic        push,
    output frame_desc_t desc
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [23:0]            shift_reg, shift_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   first_found_reg, first_found_next;
    logic [LENGTH_BITS-1:0] first_end_reg, first_end_next;
    logic                   second_found_reg, second_found_next;
    logic [LENGTH_BITS-1:0] second_end_reg, second_end_next;

    logic                   hit;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] split;
    logic                   ok1, ok2, too_short;

    // len is the saturated count including this beat; also the position past it
    assign len = (count_reg == LEN_MAX) ? count_reg : count_reg + 1'b1;
    assign hit = (shift_reg == START_PREFIX) && (beat.byte_value == VOP_CODE);

    // a hit on the last beat itself can never qualify, so registered state suffices
    assign ok1 = first_found_reg &&
        ({1'b0, first_end_reg} + (LENGTH_BITS+1)'(TAIL_BYTES) <= {1'b0, len});
    assign ok2 = ok1 && second_found_reg &&
        ({1'b0, second_end_reg} + (LENGTH_BITS+1)'(TAIL_BYTES) <= {1'b0, len});
    assign too_short = len < LENGTH_BITS'(min_length);
    assign split     = second_end_reg - LENGTH_BITS'(PREFIX_LEN);

    assign push = beat_take && beat.last_byte && !too_short;

    always_comb
    begin
        desc.offset  = beat.frame_offset;
        desc.flags   = beat.frame_flags;
        desc.offset2 = beat.frame_offset + 32'(split);
        desc.size2   = 24'(len - split);
        if (!ok1)
        begin
            desc.kind  = KIND_NOVOP;
            desc.size1 = 24'(len);
        end
        else if (!ok2)
        begin
            desc.kind  = KIND_WHOLE;
            desc.size1 = 24'(len);
        end
        else
        begin
            desc.kind  = KIND_SPLIT;
            desc.size1 = 24'(split);
        end
    end

    always_comb
    begin
        shift_next        = {shift_reg[15:0], beat.byte_value};
        count_next        = len;
        first_found_next  = first_found_reg;
        first_end_next    = first_end_reg;
        second_found_next = second_found_reg;
        second_end_next   = second_end_reg;
        if (hit && !second_found_reg)
        begin
            shift_next = CODE_SHIFT_INIT;
            if (!first_found_reg)
            begin
                first_found_next = 1'b1;
                first_end_next   = len;
            end
            else
            begin
                second_found_next = 1'b1;
                second_end_next   = len;
            end
        end
        if (beat.last_byte)
        begin
            shift_next        = CODE_SHIFT_INIT;
            count_next        = '0;
            first_found_next  = 1'b0;
            first_end_next    = '0;
            second_found_next = 1'b0;
            second_end_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg        <= CODE_SHIFT_INIT;
            count_reg        <= '0;
            first_found_reg  <= 1'b0;
            first_end_reg    <= '0;
            second_found_reg <= 1'b0;
            second_end_reg   <= '0;
        end
        else if (beat_take)
        begin
            shift_reg        <= shift_next;
            count_reg        <= count_next;
            first_found_reg  <= first_found_next;
            first_end_reg    <= first_end_next;
            second_found_reg <= second_found_next;
            second_end_reg   <= second_end_next;
        end
    end

endmodule

// ===== rtl/pbs_queue.sv =====
// short descriptor queue between front and back
module pbs_queue
    import pbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_desc_t push_desc,
    input  logic        pop,
    output frame_desc_t head,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_desc_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/pbs_back.sv =====
// back end: turns frame descriptors into one or two entry beats
module pbs_back
    import pbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_desc_t head,
    input  logic        empty,
    input  logic [31:0] b_frame_flags,
    output logic        pop,
    output logic        entry_valid,
    input  logic        entry_ready,
    output entry_beat_t entry_beat
);

    logic        out_valid_reg, out_valid_next;
    entry_beat_t out_reg, out_next;
    logic        pend_reg, pend_next;
    logic [31:0] pend_offset_reg, pend_offset_next;
    logic [23:0] pend_size_reg, pend_size_next;
    logic        slot_free;

    assign slot_free   = !out_valid_reg || entry_ready;
    assign pop         = slot_free && !pend_reg && !empty;
    assign entry_valid = out_valid_reg;
    assign entry_beat  = out_reg;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        pend_next        = pend_reg;
        pend_offset_next = pend_offset_reg;
        pend_size_next   = pend_size_reg;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
            if (pend_reg)
            begin
                // second, split-off part
                out_valid_next       = 1'b1;
                out_next.entry_offset = pend_offset_reg;
                out_next.entry_size   = pend_size_reg;
                out_next.entry_flags  = b_frame_flags;
                out_next.status       = ST_SECOND;
                out_next.last_of_run  = 1'b1;
                pend_next             = 1'b0;
            end
            else if (pop)
            begin
                out_valid_next        = 1'b1;
                out_next.entry_offset = head.offset;
                out_next.entry_size   = head.size1;
                out_next.entry_flags  = head.flags;
                out_next.last_of_run  = 1'b1;
                case (head.kind)
                    KIND_NOVOP: out_next.status = ST_NOVOP;
                    KIND_SPLIT:
                    begin
                        out_next.status      = ST_FIRST;
                        out_next.last_of_run = 1'b0;
                        pend_next            = 1'b1;
                        pend_offset_next     = head.offset2;
                        pend_size_next       = head.size2;
                    end
                    default:    out_next.status = ST_WHOLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg         <= out_next;
        pend_offset_reg <= pend_offset_next;
        pend_size_reg   <= pend_size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

endmodule

// ===== rtl/packed_bframe_splitter.sv =====
// top level of the packed b-frame splitter: config registers and pipeline
//
// byte channel: byte_valid/byte_ready/byte_beat, one frame byte per beat, with
//   last_byte marking the frame end; frame_offset and frame_flags are sampled
//   on that last beat
// entry channel: entry_valid/entry_ready/entry_beat, zero, one or two index
//   entries per frame; last_of_run marks the final entry of a frame
// config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
//   index 0 is b_frame_flags, index 1 is min_length, others are dropped
// throughput: one byte beat per cycle while the descriptor queue is not full;
//   a split frame gives two entry beats
// path: the first entry of a frame goes from the front into the descriptor
//   queue and from there into the output register
// reset: scan state cleared, queue and output empty, b_frame_flags = 0,
//   min_length = 7
// stall: when entry_ready is low the output holds; the descriptor queue keeps
//   taking frames until full, then byte_ready drops
module packed_bframe_splitter
    import pbs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  byte_beat_t             byte_beat,
    output logic                   entry_valid,
    input  logic                   entry_ready,
    output entry_beat_t            entry_beat,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [31:0] b_frame_flags_reg;
    logic [7:0]  min_length_reg;

    logic        beat_take;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    frame_desc_t push_desc;
    frame_desc_t head_desc;

    // config writes are always accepted and land in the config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_frame_flags_reg <= '0;
            min_length_reg    <= MIN_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_B_FRAME_FLAGS)
                b_frame_flags_reg <= cfg_data;
            else if (cfg_index == CFG_MIN_LENGTH)
                min_length_reg <= cfg_data[7:0];
        end
    end

    // front stalls only when the descriptor queue is full
    assign byte_ready = !q_full;
    assign beat_take  = byte_valid && byte_ready;

    pbs_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_take  (beat_take),
        .beat       (byte_beat),
        .min_length (min_length_reg),
        .push       (push),
        .desc       (push_desc)
    );

    pbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    pbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_desc),
        .empty         (q_empty),
        .b_frame_flags (b_frame_flags_reg),
        .pop           (pop),
        .entry_valid   (entry_valid),
        .entry_ready   (entry_ready),
        .entry_beat    (entry_beat)
    );

endmodule

// ===== rtl/pbs_checker.sv =====
// port-level checker for the packed b-frame splitter, bound to the top level
module pbs_checker
    import pbs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        entry_valid,
    input logic        entry_ready,
    input entry_beat_t entry_beat
);

    // a stalled entry beat holds
    a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && !entry_ready |=> entry_valid && $stable(entry_beat))
        else $error("entry beat changed while stalled");

    // a first split part is never the last entry of its frame
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry_beat.status == ST_FIRST |-> !entry_beat.last_of_run)
        else $error("first split part marked last");

    // every other kind of entry closes its frame
    a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry_beat.status != ST_FIRST |-> entry_beat.last_of_run)
        else $error("closing entry not marked last");

    // a taken first part is followed directly by its second part
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry_ready && entry_beat.status == ST_FIRST
        |=> entry_valid && entry_beat.status == ST_SECOND)
        else $error("second split part missing");

endmodule

bind packed_bframe_splitter pbs_checker u_pbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (entry_valid),
    .entry_ready (entry_ready),
    .entry_beat  (entry_beat)
);
